@@ sv/jpti_pkg.sv @@
// ----------------------------------------------------------------------------
// jpti_pkg: shared types and constants
// Command codes, register indexes, fixed-point constants and the control
// struct used between the top level and the phase unit.
// ----------------------------------------------------------------------------
`default_nettype none

package jpti_pkg;

   // Field widths fixed by the interface
   localparam int SLOTS     = 6;
   localparam int SLOT_BITS = 16;
   localparam int PROG_BITS = 20;
   localparam int CMD_BITS  = 8;
   localparam int IDX_BITS  = 8;

   localparam logic [PROG_BITS-1:0] PROG_MAX = 20'hFFFFF;
   localparam logic [16:0]          ONE_Q15  = 17'd32768;

   // Command codes
   localparam logic [CMD_BITS-1:0] TOGGLE_CMD = 8'd4;
   localparam logic [CMD_BITS-1:0] LEAVE_CMD  = 8'd2;

   // Item kinds
   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_ENTER = 1'b1;

   // Register indexes
   localparam logic [IDX_BITS-1:0] CSR_STEP       = 8'd0;
   localparam logic [IDX_BITS-1:0] CSR_HOME_A     = 8'd1;
   localparam logic [IDX_BITS-1:0] CSR_HOME_B     = 8'd2;
   localparam logic [IDX_BITS-1:0] CSR_REST_A     = 8'd3;
   localparam logic [IDX_BITS-1:0] CSR_REST_B     = 8'd4;
   localparam logic [IDX_BITS-1:0] CSR_REST_VALID = 8'd5;

   localparam logic [15:0] STEP_RESET = 16'd22;

   // Sequencer states
   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_LOOKUP = 4'b0010,
      S_INTERP = 4'b0100,
      S_MIX    = 4'b1000
   } seq_state_type;

   // Stage enables for the phase unit
   typedef struct packed {
      logic load_lookup;
      logic load_interp;
   } phase_ctl_type;

endpackage

`default_nettype wire

@@ sv/jpti_phase.sv @@
// ----------------------------------------------------------------------------
// jpti_phase: tanh easing phase
// Two-stage table lookup with linear interpolation; progress Q0.20 in,
// phase Q1.15 out. The table is built at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

module jpti_phase #(
   parameter int TANH_ENTRIES = 256
) (
   input  wire logic                              clock,
   input  wire jpti_pkg::phase_ctl_type           ctl,
   input  wire logic [jpti_pkg::PROG_BITS-1:0]    progress,
   output logic      [15:0]                       phase
);

   localparam int IW       = $clog2(TANH_ENTRIES + 1);
   localparam int POS_BITS = jpti_pkg::PROG_BITS + IW;
   localparam int FRAC     = jpti_pkg::PROG_BITS;
   localparam logic [63:0] TANH_Y = (64'd1 << 37) / 64'(TANH_ENTRIES);

   typedef logic [TANH_ENTRIES:0][15:0] tanh_tab_type;

   // Shift-subtract quotient, evaluated only while the table is built
   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], n[b]};
         if (rem >= {1'b0, d}) begin
            rem    = rem - {1'b0, d};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Entry i = round(32768*(1-e)/(1+e)), e = E^i with E = exp(-32/N) in Q0.32
   function automatic tanh_tab_type build_tab(input logic [63:0] y);
      logic [63:0]  one;
      logic [63:0]  term;
      logic [63:0]  base;
      logic [63:0]  e;
      logic [63:0]  num;
      logic [63:0]  den;
      logic [4:0]   kb;
      tanh_tab_type t;
      one  = 64'd1 << 32;
      term = one;
      base = one;
      e    = one;
      for (int k = 1; k <= 20; k++) begin
         kb   = 5'(k);
         term = udiv64((term * y) >> 32, 64'(k));
         if (kb[0]) begin
            base = base - term;
         end else begin
            base = base + term;
         end
      end
      for (int i = 0; i <= TANH_ENTRIES; i++) begin
         num  = (one - e) * 64'(jpti_pkg::ONE_Q15);
         den  = one + e;
         t[i] = 16'(udiv64(num + (den >> 1), den));
         e    = (e * base + (64'd1 << 31)) >> 32;
      end
      return t;
   endfunction

   localparam tanh_tab_type TANH_TAB = build_tab(TANH_Y);

   logic [POS_BITS-1:0] pos;
   logic [IW-1:0]       idx;
   logic [IW-1:0]       idx_next;
   logic [FRAC-1:0]     frac;
   logic [15:0]         t0;
   logic [15:0]         t1;

   logic [15:0]         base_ff,  base_in;
   logic [15:0]         diff_ff,  diff_in;
   logic [FRAC-1:0]     frac_ff;
   logic [35:0]         slope;
   logic [15:0]         phase_ff, phase_in;

   // Lookup stage
   always_comb begin
      pos      = POS_BITS'(progress) * POS_BITS'(TANH_ENTRIES);
      idx      = pos[FRAC +: IW];
      idx_next = idx + IW'(1);
      frac     = pos[FRAC-1:0];
      if (idx >= IW'(TANH_ENTRIES)) begin
         t0 = TANH_TAB[TANH_ENTRIES];
         t1 = TANH_TAB[TANH_ENTRIES];
      end else begin
         t0 = TANH_TAB[idx];
         t1 = TANH_TAB[idx_next];
      end
      base_in = t0;
      diff_in = (t1 < t0) ? 16'd0 : (t1 - t0);
   end

   // Interpolation stage
   always_comb begin
      slope    = 36'(diff_ff) * 36'(frac_ff) + (36'd1 << (FRAC - 1));
      phase_in = base_ff + 16'(slope >> FRAC);
   end

   always_ff @(posedge clock) begin
      if (ctl.load_lookup) begin
         base_ff <= base_in;
         diff_ff <= diff_in;
         frac_ff <= frac;
      end
      if (ctl.load_interp) begin
         phase_ff <= phase_in;
      end
   end

   assign phase = phase_ff;

endmodule

`default_nettype wire

@@ sv/jpti_lane.sv @@
// ----------------------------------------------------------------------------
// jpti_lane: one joint blend
// Mixes start and target by the phase: floor((ph*tgt + (1-ph)*start + half)
// / 2^15), a convex mix that stays in the position range.
// ----------------------------------------------------------------------------
`default_nettype none

module jpti_lane (
   input  wire logic        [15:0] phase,
   input  wire logic signed [15:0] target,
   input  wire logic signed [15:0] start,
   output logic signed      [15:0] cmd_pos
);

   logic signed [16:0] ph_s;
   logic signed [16:0] inv_s;
   logic signed [32:0] prod_tgt;
   logic signed [32:0] prod_start;
   logic        [33:0] mix;

   always_comb begin
      ph_s       = $signed({1'b0, phase});
      inv_s      = $signed(jpti_pkg::ONE_Q15 - {1'b0, phase});
      prod_tgt   = ph_s * target;
      prod_start = inv_s * start;
      mix        = {prod_tgt[32], prod_tgt} + {prod_start[32], prod_start} + 34'd16384;
      // arithmetic shift by 15, keep the position bits
      cmd_pos    = $signed(mix[30:15]);
   end

endmodule

`default_nettype wire

@@ sv/joint_pose_tanh_interpolator_top.sv @@
// ----------------------------------------------------------------------------
// A tick steps through accept, table lookup, interpolation and lane mix; requests
// stall until the sequencer is back in idle, so no new item is taken before the
// last tick is through. An enter item returns nothing. A stalled result holds the
// lane mix, and the next item waits until the output register frees.
// Reset (synchronous): progress, start positions, pose and debounce cleared,
// step register to 22, pose registers and rest enable to 0.
// ----------------------------------------------------------------------------
// joint_pose_tanh_interpolator_top: joint-space pose interpolator
// Per tick: debounced pose toggle, saturating progress, tanh phase, and a
// lane per joint, up to six, blending start and target positions.
// ----------------------------------------------------------------------------
`default_nettype none

module joint_pose_tanh_interpolator_top #(
   parameter int NUM_JOINTS   = 6,
   parameter int TANH_ENTRIES = 256,
   parameter int POS_WIDTH    = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,

   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_kind,
   input  wire logic [7:0]         req_command,
   input  wire logic signed [15:0] req_measured_pos_0,
   input  wire logic signed [15:0] req_measured_pos_1,
   input  wire logic signed [15:0] req_measured_pos_2,
   input  wire logic signed [15:0] req_measured_pos_3,
   input  wire logic signed [15:0] req_measured_pos_4,
   input  wire logic signed [15:0] req_measured_pos_5,

   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_cmd_pos_0,
   output logic signed [15:0]      rsp_cmd_pos_1,
   output logic signed [15:0]      rsp_cmd_pos_2,
   output logic signed [15:0]      rsp_cmd_pos_3,
   output logic signed [15:0]      rsp_cmd_pos_4,
   output logic signed [15:0]      rsp_cmd_pos_5,
   output logic                    rsp_leave_request,
   output logic                    rsp_at_rest_pose,

   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [7:0]         csr_index,
   input  wire logic [63:0]        csr_wdata
);

   localparam int SLOTS     = jpti_pkg::SLOTS;
   localparam int LANES     = (NUM_JOINTS > SLOTS) ? SLOTS : NUM_JOINTS;
   localparam int PW        = (POS_WIDTH > 16) ? 16 : POS_WIDTH;
   localparam int POS_SHIFT = 16 - PW;
   localparam int PB        = jpti_pkg::PROG_BITS;

   function automatic logic signed [15:0] sext_pos(input logic [15:0] v);
      logic signed [15:0] t;
      t = $signed(v << POS_SHIFT);
      return t >>> POS_SHIFT;
   endfunction

   // Configuration registers
   logic [15:0] step_ff;
   logic [63:0] home_a_ff;
   logic [31:0] home_b_ff;
   logic [63:0] rest_a_ff;
   logic [31:0] rest_b_ff;
   logic        rest_cfg_ff;

   // Move state
   jpti_pkg::seq_state_type state_ff, state_in;
   logic [PB-1:0]      progress_ff, progress_in;
   logic signed [15:0] start_ff [SLOTS];
   logic signed [15:0] meas [SLOTS];
   logic               rest_sel_ff, rest_sel_in;
   logic               last_tog_ff, last_tog_in;
   logic               latched_ff, latched_in;
   logic               leave_ff;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_pos_ff [SLOTS];
   logic               rsp_leave_ff;
   logic               rsp_rest_ff;

   logic               req_xfer;
   logic               tick_xfer;
   logic               enter_xfer;
   logic               out_free;
   logic               rsp_load;
   logic               cur_tog;
   logic               fire;
   logic               do_toggle;
   logic [PB-1:0]      prog_base;
   logic [PB:0]        prog_sum;

   jpti_pkg::phase_ctl_type phase_ctl;
   logic [15:0]             phase;
   logic signed [15:0]      lane_pos [SLOTS];
   logic [63:0]             tgt_a;
   logic [31:0]             tgt_b;

   assign meas[0] = sext_pos(req_measured_pos_0);
   assign meas[1] = sext_pos(req_measured_pos_1);
   assign meas[2] = sext_pos(req_measured_pos_2);
   assign meas[3] = sext_pos(req_measured_pos_3);
   assign meas[4] = sext_pos(req_measured_pos_4);
   assign meas[5] = sext_pos(req_measured_pos_5);

   assign csr_ready  = 1'b1;
   assign req_stall  = (state_ff != jpti_pkg::S_IDLE);
   assign req_xfer   = req_valid && !req_stall;
   assign tick_xfer  = req_xfer && (req_kind == jpti_pkg::KIND_TICK);
   assign enter_xfer = req_xfer && (req_kind == jpti_pkg::KIND_ENTER);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_load   = (state_ff == jpti_pkg::S_MIX) && out_free;

   // Debounced toggle and saturating progress
   always_comb begin
      cur_tog     = (req_command == jpti_pkg::TOGGLE_CMD);
      fire        = cur_tog && !last_tog_ff && !latched_ff;
      do_toggle   = fire && rest_cfg_ff;
      prog_base   = do_toggle ? '0 : progress_ff;
      prog_sum    = {1'b0, prog_base} + (PB+1)'(step_ff);
      progress_in = progress_ff;
      rest_sel_in = rest_sel_ff;
      last_tog_in = last_tog_ff;
      latched_in  = latched_ff;
      if (enter_xfer) begin
         progress_in = '0;
         rest_sel_in = 1'b0;
      end else if (tick_xfer) begin
         progress_in = prog_sum[PB] ? jpti_pkg::PROG_MAX : prog_sum[PB-1:0];
         rest_sel_in = do_toggle ? !rest_sel_ff : rest_sel_ff;
         last_tog_in = cur_tog;
         latched_in  = cur_tog && (latched_ff || fire);
      end
   end

   // Sequencer
   always_comb begin
      state_in              = state_ff;
      phase_ctl.load_lookup = 1'b0;
      phase_ctl.load_interp = 1'b0;
      unique case (state_ff)
         jpti_pkg::S_IDLE: begin
            if (tick_xfer) begin
               state_in = jpti_pkg::S_LOOKUP;
            end
         end
         jpti_pkg::S_LOOKUP: begin
            phase_ctl.load_lookup = 1'b1;
            state_in              = jpti_pkg::S_INTERP;
         end
         jpti_pkg::S_INTERP: begin
            phase_ctl.load_interp = 1'b1;
            state_in              = jpti_pkg::S_MIX;
         end
         jpti_pkg::S_MIX: begin
            if (out_free) begin
               state_in = jpti_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = jpti_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jpti_pkg::S_IDLE;
         progress_ff  <= '0;
         rest_sel_ff  <= 1'b0;
         last_tog_ff  <= 1'b0;
         latched_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= jpti_pkg::STEP_RESET;
         home_a_ff    <= '0;
         home_b_ff    <= '0;
         rest_a_ff    <= '0;
         rest_b_ff    <= '0;
         rest_cfg_ff  <= 1'b0;
         for (int j = 0; j < SLOTS; j++) begin
            start_ff[j] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         progress_ff  <= progress_in;
         rest_sel_ff  <= rest_sel_in;
         last_tog_ff  <= last_tog_in;
         latched_ff   <= latched_in;
         rsp_valid_ff <= rsp_valid_in;
         // capture start positions on enter or on a taken toggle
         if (enter_xfer || (tick_xfer && do_toggle)) begin
            for (int j = 0; j < SLOTS; j++) begin
               start_ff[j] <= meas[j];
            end
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               jpti_pkg::CSR_STEP:       step_ff     <= csr_wdata[15:0];
               jpti_pkg::CSR_HOME_A:     home_a_ff   <= csr_wdata;
               jpti_pkg::CSR_HOME_B:     home_b_ff   <= csr_wdata[31:0];
               jpti_pkg::CSR_REST_A:     rest_a_ff   <= csr_wdata;
               jpti_pkg::CSR_REST_B:     rest_b_ff   <= csr_wdata[31:0];
               jpti_pkg::CSR_REST_VALID: rest_cfg_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tick_xfer) begin
         leave_ff <= (req_command == jpti_pkg::LEAVE_CMD);
      end
      if (rsp_load) begin
         rsp_leave_ff <= leave_ff;
         rsp_rest_ff  <= rest_sel_ff;
         for (int j = 0; j < SLOTS; j++) begin
            rsp_pos_ff[j] <= lane_pos[j];
         end
      end
   end

   jpti_phase #(
      .TANH_ENTRIES (TANH_ENTRIES)
   ) u_phase (
      .clock    (clock),
      .ctl      (phase_ctl),
      .progress (progress_ff),
      .phase    (phase)
   );

   assign tgt_a = rest_sel_ff ? rest_a_ff : home_a_ff;
   assign tgt_b = rest_sel_ff ? rest_b_ff : home_b_ff;

   for (genvar j = 0; j < SLOTS; j++) begin : g_lane
      if (j < LANES) begin : g_on
         logic signed [15:0] target;
         if (j < 4) begin : g_a
            assign target = sext_pos(tgt_a[16*j +: 16]);
         end else begin : g_b
            assign target = sext_pos(tgt_b[16*(j-4) +: 16]);
         end
         jpti_lane u_lane (
            .phase   (phase),
            .target  (target),
            .start   (start_ff[j]),
            .cmd_pos (lane_pos[j])
         );
      end else begin : g_off
         assign lane_pos[j] = '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cmd_pos_0     = rsp_pos_ff[0];
   assign rsp_cmd_pos_1     = rsp_pos_ff[1];
   assign rsp_cmd_pos_2     = rsp_pos_ff[2];
   assign rsp_cmd_pos_3     = rsp_pos_ff[3];
   assign rsp_cmd_pos_4     = rsp_pos_ff[4];
   assign rsp_cmd_pos_5     = rsp_pos_ff[5];
   assign rsp_leave_request = rsp_leave_ff;
   assign rsp_at_rest_pose  = rsp_rest_ff;

   // A tick walks the pipeline in fixed order
   a_tick_to_lookup: assert property (@(posedge clock) disable iff (reset)
      tick_xfer |=> (state_ff == jpti_pkg::S_LOOKUP) ##1 (state_ff == jpti_pkg::S_INTERP))
      else $error("tick did not enter lookup and interpolation in order");

   // Enter restarts the move from the home pose
   a_enter_clears: assert property (@(posedge clock) disable iff (reset)
      enter_xfer |=> (progress_ff == '0) && !rest_sel_ff && (state_ff == jpti_pkg::S_IDLE))
      else $error("enter did not clear progress and pose");

   // Phase handed to the lanes never exceeds one
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> ({1'b0, phase} <= jpti_pkg::ONE_Q15))
      else $error("phase above one at lane mix");

   // Finished lanes hold while the output register is occupied
   a_mix_hold: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == jpti_pkg::S_MIX) && !out_free) |=>
         (state_ff == jpti_pkg::S_MIX) && rsp_valid)
      else $error("lane result dropped while output stalled");

   // A loaded result is presented on the next cycle
   a_load_presents: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid && (rsp_at_rest_pose == $past(rest_sel_ff)))
      else $error("result not presented after load");

endmodule

`default_nettype wire
